// File: hw/rtl/im2col_pkg.sv
`timescale 1ns / 1ps

package im2col_pkg;

  // Defaults of the top-level parameters.
  localparam int MAX_KERNEL_DIM_DEFAULT = 8;
  localparam int INDEX_BITS_DEFAULT     = 40;

  // Fixed field widths.
  localparam int BATCH_W       = 8;
  localparam int DIM_W         = 16;
  localparam int CHAN_W        = 12;
  localparam int CHAN_COUNT_W  = 13;
  localparam int KSIZE_W       = 12;
  localparam int PAIR_W        = 16;
  localparam int STEP_W        = 8;
  localparam int TAP_W         = 3;
  localparam int KDIM_W        = 4;
  localparam int TAPS_W        = 7;
  localparam int SCALED_W      = DIM_W + STEP_W;
  localparam int POS_W         = SCALED_W + 2;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 32;

  // The shared multiplier takes one 32-bit digit of its wide operand a cycle.
  localparam int MUL_W          = 32;
  localparam int MAX_INDEX_BITS = 64;
  localparam int DIGIT_W        = $clog2(MAX_INDEX_BITS / MUL_W);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IN_SIZE       = 3'd0,
    REG_OUT_SIZE      = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_KERNEL_SIZE   = 3'd3,
    REG_STRIDE_PAIR   = 3'd4,
    REG_PADDING_PAIR  = 3'd5,
    REG_DILATION_PAIR = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_TAPS
  } state_t;

  // Setup operations, in issue order. Each one is acc = a * b + c.
  typedef enum logic [3:0] {
    OP_N_OH,
    OP_N_OH_OW,
    OP_P,
    OP_PC,
    OP_COL,
    OP_NC,
    OP_HW,
    OP_SRC,
    OP_ROW
  } op_t;

  typedef struct packed {
    logic [31:0]             in_size;
    logic [31:0]             out_size;
    logic [CHAN_COUNT_W-1:0] channel_count;
    logic [KSIZE_W-1:0]      kernel_size;
    logic [PAIR_W-1:0]       stride_pair;
    logic [PAIR_W-1:0]       padding_pair;
    logic [PAIR_W-1:0]       dilation_pair;
  } cfg_t;

  typedef struct packed {
    logic [BATCH_W-1:0] batch_index;
    logic [DIM_W-1:0]   out_row;
    logic [DIM_W-1:0]   out_column;
    logic [CHAN_W-1:0]  channel;
  } item_t;

  typedef struct packed {
    logic               load;
    logic               mul_en;
    logic               mul_first;
    logic               mul_last;
    op_t                op;
    logic [DIGIT_W-1:0] digit;
    logic               tap_init;
    logic               emit;
  } cmd_t;

  typedef struct packed {
    logic out_space;
    logic last_tap;
  } status_t;

  function automatic op_t next_op(input op_t op);
    op_t nxt;
    unique case (op)
      OP_N_OH:    nxt = OP_N_OH_OW;
      OP_N_OH_OW: nxt = OP_P;
      OP_P:       nxt = OP_PC;
      OP_PC:      nxt = OP_COL;
      OP_COL:     nxt = OP_NC;
      OP_NC:      nxt = OP_HW;
      OP_HW:      nxt = OP_SRC;
      OP_SRC:     nxt = OP_ROW;
      default:    nxt = OP_N_OH;
    endcase
    return nxt;
  endfunction

  function automatic logic [KDIM_W-1:0] clamp_dim(input logic [7:0] v,
                                                   input logic [KDIM_W-1:0] max_dim);
    logic [KDIM_W-1:0] r;
    if (v == 8'd0) begin
      r = KDIM_W'(1);
    end else if (v > 8'(max_dim)) begin
      r = max_dim;
    end else begin
      r = v[KDIM_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/im2col_ifs.sv
`timescale 1ns / 1ps

interface im2col_item_if;
  import im2col_pkg::*;
  logic               valid;
  logic               ready;
  logic [BATCH_W-1:0] batch_index;
  logic [DIM_W-1:0]   out_row;
  logic [DIM_W-1:0]   out_column;
  logic [CHAN_W-1:0]  channel;

  modport source(output valid, batch_index, out_row, out_column, channel, input ready);
  modport sink(input valid, batch_index, out_row, out_column, channel, output ready);
endinterface

interface im2col_result_if #(
  parameter int IndexBits = im2col_pkg::INDEX_BITS_DEFAULT
);
  import im2col_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [IndexBits-1:0] source_index;
  logic [IndexBits-1:0] column_index;
  logic                 is_padding;
  logic [TAP_W-1:0]     tap_row;
  logic [TAP_W-1:0]     tap_column;
  logic                 last;

  modport source(output valid, source_index, column_index, is_padding, tap_row, tap_column,
                 last, input ready);
  modport sink(input valid, source_index, column_index, is_padding, tap_row, tap_column,
               last, output ready);
endinterface

interface im2col_cfg_if;
  import im2col_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: hw/rtl/im2col_regs.sv
`timescale 1ns / 1ps

module im2col_regs (
  input  logic                clk,
  input  logic                rst,
  im2col_cfg_if.sink          cfg,
  output im2col_pkg::cfg_t    regs
);
  import im2col_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.in_size       <= '0;
      regs.out_size      <= '0;
      regs.channel_count <= CHAN_COUNT_W'(1);
      regs.kernel_size   <= KSIZE_W'(12'h101);
      regs.stride_pair   <= PAIR_W'(16'h0101);
      regs.padding_pair  <= '0;
      regs.dilation_pair <= PAIR_W'(16'h0101);
    end else if (cfg.valid) begin
      // Writes to an index past the register list are dropped.
      unique case (cfg.index)
        REG_IN_SIZE:       regs.in_size       <= cfg.data;
        REG_OUT_SIZE:      regs.out_size      <= cfg.data;
        REG_CHANNEL_COUNT: regs.channel_count <= cfg.data[CHAN_COUNT_W-1:0];
        REG_KERNEL_SIZE:   regs.kernel_size   <= cfg.data[KSIZE_W-1:0];
        REG_STRIDE_PAIR:   regs.stride_pair   <= cfg.data[PAIR_W-1:0];
        REG_PADDING_PAIR:  regs.padding_pair  <= cfg.data[PAIR_W-1:0];
        REG_DILATION_PAIR: regs.dilation_pair <= cfg.data[PAIR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/im2col_ctrl.sv
`timescale 1ns / 1ps

module im2col_ctrl #(
  parameter int INDEX_BITS = im2col_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  im2col_pkg::status_t status,
  output im2col_pkg::cmd_t    cmd
);
  import im2col_pkg::*;

  localparam int DIGITS = (INDEX_BITS + MUL_W - 1) / MUL_W;
  localparam logic [DIGIT_W-1:0] LAST_DIGIT = DIGIT_W'(DIGITS - 1);

  state_t             state, state_next;
  op_t                op, op_next;
  logic [DIGIT_W-1:0] digit, digit_next;
  logic               digit_last;

  assign digit_last = (digit == LAST_DIGIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_N_OH;
      digit <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      digit <= digit_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    digit_next = digit;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SETUP;
          op_next    = OP_N_OH;
          digit_next = '0;
        end
      end
      S_SETUP: begin
        if (digit_last) begin
          digit_next = '0;
          op_next    = next_op(op);
          if (op == OP_ROW) begin
            state_next = S_TAPS;
          end
        end else begin
          digit_next = digit + 1'b1;
        end
      end
      S_TAPS: begin
        if (status.out_space && status.last_tap) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.op    = op;
    cmd.digit = digit;
    in_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SETUP: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_first = (digit == '0);
        cmd.mul_last  = digit_last;
        // The row base lands on the same edge that the tap walk starts.
        cmd.tap_init  = digit_last && (op == OP_ROW);
      end
      S_TAPS: begin
        cmd.emit = status.out_space;
      end
      default: ;
    endcase
  end

  a_load_starts_setup: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_SETUP && op == OP_N_OH && digit == '0))
    else $error("item load did not start the setup sequence");

  a_init_enters_taps: assert property (@(posedge clk) disable iff (rst)
    cmd.tap_init |=> (state == S_TAPS))
    else $error("tap walk did not follow the last setup operation");

  a_taps_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAPS && !(cmd.emit && status.last_tap)) |=> (state == S_TAPS))
    else $error("tap walk left before the last tap was issued");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.mul_en, cmd.emit}))
    else $error("load, multiply and emit overlap");

endmodule

// File: hw/rtl/im2col_dp.sv
`timescale 1ns / 1ps

module im2col_dp #(
  parameter int INDEX_BITS     = im2col_pkg::INDEX_BITS_DEFAULT,
  parameter int MAX_KERNEL_DIM = im2col_pkg::MAX_KERNEL_DIM_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  im2col_pkg::cfg_t                   cfg,
  input  im2col_pkg::item_t                  item_fields,
  input  im2col_pkg::cmd_t                   cmd,
  output im2col_pkg::status_t                status,
  input  logic                               result_ready,
  output logic                               result_valid,
  output logic [INDEX_BITS-1:0]              source_index,
  output logic [INDEX_BITS-1:0]              column_index,
  output logic                               is_padding,
  output logic [im2col_pkg::TAP_W-1:0]       tap_row,
  output logic [im2col_pkg::TAP_W-1:0]       tap_column,
  output logic                               last
);
  import im2col_pkg::*;

  localparam int IB     = INDEX_BITS;
  localparam int DIGITS = (IB + MUL_W - 1) / MUL_W;
  localparam int ABITS  = DIGITS * MUL_W;
  localparam int PW     = ABITS + MUL_W;

  // Configuration fields.
  logic [DIM_W-1:0]        in_h, in_w, out_h, out_w;
  logic [CHAN_COUNT_W-1:0] ch;
  logic [KDIM_W-1:0]       kh, kw;
  logic [STEP_W-1:0]       sv, sh, pv, ph, dv, dh;

  assign in_h  = cfg.in_size[31:16];
  assign in_w  = cfg.in_size[15:0];
  assign out_h = cfg.out_size[31:16];
  assign out_w = cfg.out_size[15:0];
  assign ch    = cfg.channel_count;
  assign kh    = clamp_dim({4'd0, cfg.kernel_size[11:8]}, KDIM_W'(MAX_KERNEL_DIM));
  assign kw    = clamp_dim(cfg.kernel_size[7:0], KDIM_W'(MAX_KERNEL_DIM));
  assign sv    = cfg.stride_pair[15:8];
  assign sh    = cfg.stride_pair[7:0];
  assign pv    = cfg.padding_pair[15:8];
  assign ph    = cfg.padding_pair[7:0];
  assign dv    = cfg.dilation_pair[15:8];
  assign dh    = cfg.dilation_pair[7:0];

  // Item registers and values derived at load.
  logic [BATCH_W-1:0]  n_r;
  logic [DIM_W-1:0]    oh_r, ow_r;
  logic [CHAN_W-1:0]   c_r;
  logic [TAPS_W-1:0]   taps_r;
  logic [POS_W-1:0]    hi0_r, wi0_r;
  logic [SCALED_W-1:0] dvw_r;
  logic [SCALED_W-1:0] row_scaled, col_scaled, dvw_next;

  assign row_scaled = SCALED_W'(item_fields.out_row) * SCALED_W'(sv);
  assign col_scaled = SCALED_W'(item_fields.out_column) * SCALED_W'(sh);
  assign dvw_next   = SCALED_W'(dv) * SCALED_W'(in_w);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r    <= item_fields.batch_index;
      oh_r   <= item_fields.out_row;
      ow_r   <= item_fields.out_column;
      c_r    <= item_fields.channel;
      taps_r <= TAPS_W'(8'(kh) * 8'(kw));
      hi0_r  <= POS_W'(row_scaled) - POS_W'(pv);
      wi0_r  <= POS_W'(col_scaled) - POS_W'(ph);
      dvw_r  <= dvw_next;
    end
  end

  // Shared multiplier: acc = a * b + c, one digit of a per cycle, modulo 2^IB.
  logic [IB-1:0]        pr, colbase, nc, hw, srcbase, rowsrc, acc;
  logic [ABITS-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b, mul_digit;
  logic [IB-1:0]        mul_c, acc_next;
  logic [2*MUL_W-1:0]   mul_prod;
  logic [PW-1:0]        mul_shift;
  logic [63:0]          hi0_wide;

  assign hi0_wide = {{(64 - POS_W){hi0_r[POS_W-1]}}, hi0_r};

  always_comb begin
    unique case (cmd.op)
      OP_N_OH: begin
        mul_a = ABITS'(n_r);
        mul_b = MUL_W'(out_h);
        mul_c = '0;
      end
      OP_N_OH_OW: begin
        mul_a = ABITS'(pr);
        mul_b = MUL_W'(out_w);
        mul_c = IB'(ow_r);
      end
      OP_P: begin
        mul_a = ABITS'(oh_r);
        mul_b = MUL_W'(out_w);
        mul_c = pr;
      end
      OP_PC: begin
        mul_a = ABITS'(pr);
        mul_b = MUL_W'(ch);
        mul_c = IB'(c_r);
      end
      OP_COL: begin
        mul_a = ABITS'(pr);
        mul_b = MUL_W'(taps_r);
        mul_c = '0;
      end
      OP_NC: begin
        mul_a = ABITS'(n_r);
        mul_b = MUL_W'(ch);
        mul_c = IB'(c_r);
      end
      OP_HW: begin
        mul_a = ABITS'(in_h);
        mul_b = MUL_W'(in_w);
        mul_c = '0;
      end
      OP_SRC: begin
        mul_a = ABITS'(nc);
        mul_b = MUL_W'(hw);
        mul_c = '0;
      end
      OP_ROW: begin
        // The first row position may be negative; two's complement keeps the sum exact.
        mul_a = ABITS'(hi0_wide[IB-1:0]);
        mul_b = MUL_W'(in_w);
        mul_c = srcbase;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
        mul_c = '0;
      end
    endcase
  end

  assign mul_digit = mul_a[cmd.digit * MUL_W +: MUL_W];
  assign mul_prod  = (2 * MUL_W)'(mul_digit) * (2 * MUL_W)'(mul_b);
  assign mul_shift = PW'(mul_prod) << (cmd.digit * MUL_W);
  assign acc_next  = (cmd.mul_first ? mul_c : acc) + mul_shift[IB-1:0];

  // Tap walk state.
  logic [TAP_W-1:0] tr, tc;
  logic [POS_W-1:0] hi, wi;
  logic [IB-1:0]    col;
  logic             row_end, pad, hi_out, wi_out;
  logic [IB-1:0]    src_now;

  assign row_end         = ({1'b0, tc} == kw - 1'b1);
  assign status.last_tap = row_end && ({1'b0, tr} == kh - 1'b1);

  assign hi_out  = hi[POS_W-1] || (hi[POS_W-2:0] >= (POS_W - 1)'(in_h));
  assign wi_out  = wi[POS_W-1] || (wi[POS_W-2:0] >= (POS_W - 1)'(in_w));
  assign pad     = hi_out || wi_out;
  // Inside the image the column position is below the width, so 16 bits hold it.
  assign src_now = pad ? '0 : rowsrc + IB'(wi[DIM_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      acc <= acc_next;
      if (cmd.mul_last) begin
        unique case (cmd.op)
          OP_N_OH, OP_N_OH_OW, OP_P, OP_PC: pr <= acc_next;
          OP_COL: colbase <= acc_next;
          OP_NC:  nc      <= acc_next;
          OP_HW:  hw      <= acc_next;
          OP_SRC: srcbase <= acc_next;
          OP_ROW: rowsrc  <= acc_next;
          default: ;
        endcase
      end
    end
    if (cmd.tap_init) begin
      tr  <= '0;
      tc  <= '0;
      hi  <= hi0_r;
      wi  <= wi0_r;
      col <= colbase;
    end else if (cmd.emit) begin
      col <= col + 1'b1;
      if (row_end) begin
        tc     <= '0;
        tr     <= tr + 1'b1;
        wi     <= wi0_r;
        hi     <= hi + POS_W'(dv);
        rowsrc <= rowsrc + IB'(dvw_r);
      end else begin
        tc <= tc + 1'b1;
        wi <= wi + POS_W'(dh);
      end
    end
  end

  // Output register.
  assign status.out_space = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      source_index <= src_now;
      column_index <= col;
      is_padding   <= pad;
      tap_row      <= tr;
      tap_column   <= tc;
      last         <= status.last_tap;
    end
  end

endmodule

// File: hw/rtl/im2col_address_generator_core.sv
`timescale 1ns / 1ps

// im2col address generator: each item (batch, output row, output column, channel) expands
// into one result per kernel tap, kernel rows outer and columns inner, carrying the column
// matrix index, the NCHW source index (zero on a padding tap), the tap position and a last
// flag. An item is accepted only while the block is idle, then computes its base indices
// on one shared multiplier that takes a 32-bit digit per cycle, then issues its KH * KW
// results, one per cycle while the output is taken. The cycle after the last result is
// registered, the next item can be accepted. Kernel dimensions are clamped to
// 1..MAX_KERNEL_DIM, indices wrap modulo 2^INDEX_BITS, and configuration must be written
// only while the block is idle; the block itself does not enforce this.
module im2col_address_generator_core #(
  parameter int MAX_KERNEL_DIM = im2col_pkg::MAX_KERNEL_DIM_DEFAULT,
  parameter int INDEX_BITS     = im2col_pkg::INDEX_BITS_DEFAULT
) (
  input logic           clk,
  input logic           rst,
  im2col_cfg_if.sink    cfg,
  im2col_item_if.sink   item,
  im2col_result_if.source result
);
  import im2col_pkg::*;

  cfg_t    regs;
  item_t   item_fields;
  cmd_t    cmd;
  status_t status;

  logic [INDEX_BITS-1:0] source_index, column_index;
  logic                  is_padding, last, result_valid;
  logic [TAP_W-1:0]      tap_row, tap_column;

  assign item_fields.batch_index = item.batch_index;
  assign item_fields.out_row     = item.out_row;
  assign item_fields.out_column  = item.out_column;
  assign item_fields.channel     = item.channel;

  im2col_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  im2col_ctrl #(
    .INDEX_BITS (INDEX_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  im2col_dp #(
    .INDEX_BITS     (INDEX_BITS),
    .MAX_KERNEL_DIM (MAX_KERNEL_DIM)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (regs),
    .item_fields  (item_fields),
    .cmd          (cmd),
    .status       (status),
    .result_ready (result.ready),
    .result_valid (result_valid),
    .source_index (source_index),
    .column_index (column_index),
    .is_padding   (is_padding),
    .tap_row      (tap_row),
    .tap_column   (tap_column),
    .last         (last)
  );

  assign result.valid        = result_valid;
  assign result.source_index = source_index;
  assign result.column_index = column_index;
  assign result.is_padding   = is_padding;
  assign result.tap_row      = tap_row;
  assign result.tap_column   = tap_column;
  assign result.last         = last;

endmodule
